// ----- rtl/masme_pkg.sv -----
// ----------------------------------------------------------------------------
// masme_pkg
// shared types and codes of the matrix add, subtract and multiply engine
// ----------------------------------------------------------------------------
package masme_pkg;

  localparam int RES_W  = 40;
  localparam int ELEM_W = 16;
  localparam int REG_W  = 5;
  localparam int IDX_W  = 3;

  // operation codes
  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_SUB = 2'd1;
  localparam logic [1:0] OP_MUL = 2'd2;

  // result status codes
  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_MISMATCH = 2'd1;
  localparam logic [1:0] STAT_EARLY    = 2'd2;

  // register indexes
  localparam logic [IDX_W-1:0] REG_OP_MODE = 3'd0;
  localparam logic [IDX_W-1:0] REG_A_ROWS  = 3'd1;
  localparam logic [IDX_W-1:0] REG_A_COLS  = 3'd2;
  localparam logic [IDX_W-1:0] REG_B_ROWS  = 3'd3;
  localparam logic [IDX_W-1:0] REG_B_COLS  = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_ISSUE,
    ST_DRAIN,
    ST_OUT_OK,
    ST_OUT_MISMATCH,
    ST_OUT_EARLY
  } state_t;

  typedef enum logic [1:0] {
    OUT_OK,
    OUT_MISMATCH,
    OUT_EARLY
  } out_kind_t;

  typedef struct packed {
    logic      load_elem;
    logic      read_start;
    logic      div_step;
    logic      mac_init;
    logic      issue;
    logic      out_load;
    out_kind_t out_kind;
  } ctrl_cmd_t;

  typedef struct packed {
    logic loaded_all;
    logic shape_ok;
    logic div_done;
    logic issue_last;
    logic pipe_busy;
    logic out_free;
  } dp_stat_t;

endpackage

// ----- rtl/masme_ctrl.sv -----
// ----------------------------------------------------------------------------
// masme_ctrl
// sequencer: read decode, row divide, mac issue, drain and result hand-off
// ----------------------------------------------------------------------------
module masme_ctrl
  import masme_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  logic      req_type,
  input  dp_stat_t  stat,
  output logic      in_stall,
  output ctrl_cmd_t cmd
);

  state_t state, state_next;
  logic   accept;

  assign accept = in_valid && (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && req_type) begin
          priority if (!stat.loaded_all) state_next = ST_OUT_EARLY;
          else if (!stat.shape_ok)       state_next = ST_OUT_MISMATCH;
          else                           state_next = ST_DIV;
        end
      end
      ST_DIV:          if (stat.div_done) state_next = ST_ISSUE;
      ST_ISSUE:        if (stat.issue_last) state_next = ST_DRAIN;
      ST_DRAIN:        if (!stat.pipe_busy) state_next = ST_OUT_OK;
      ST_OUT_OK,
      ST_OUT_MISMATCH,
      ST_OUT_EARLY:    if (stat.out_free) state_next = ST_IDLE;
      default:         state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall       = (state != ST_IDLE);
    cmd            = '0;
    cmd.out_kind   = OUT_OK;
    unique case (state)
      ST_IDLE: begin
        cmd.load_elem  = accept && !req_type;
        cmd.read_start = accept && req_type;
      end
      ST_DIV: begin
        cmd.div_step = !stat.div_done;
        cmd.mac_init = stat.div_done;
      end
      ST_ISSUE: cmd.issue = 1'b1;
      ST_DRAIN: cmd = '0;
      ST_OUT_OK: begin
        cmd.out_load = stat.out_free;
        cmd.out_kind = OUT_OK;
      end
      ST_OUT_MISMATCH: begin
        cmd.out_load = stat.out_free;
        cmd.out_kind = OUT_MISMATCH;
      end
      ST_OUT_EARLY: begin
        cmd.out_load = stat.out_free;
        cmd.out_kind = OUT_EARLY;
      end
      default: cmd = '0;
    endcase
  end

endmodule

// ----- rtl/masme_dp.sv -----
// ----------------------------------------------------------------------------
// masme_dp
// datapath: registers, element stores, counters, row divider, mac, output
// ----------------------------------------------------------------------------
module masme_dp
  import masme_pkg::*;
#(
  parameter int MAX_DIM    = 16,
  parameter int ELEM_WIDTH = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic [IDX_W-1:0]        cfg_index,
  input  logic [REG_W-1:0]        cfg_data,
  input  logic signed [ELEM_W-1:0] element,
  input  ctrl_cmd_t               cmd,
  input  logic                    out_stall,
  output dp_stat_t                stat,
  output logic                    out_valid,
  output logic signed [RES_W-1:0] result_value,
  output logic                    is_last,
  output logic [1:0]              status
);

  localparam int DEPTH  = MAX_DIM * MAX_DIM;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NA_W   = $clog2(DEPTH + 1);
  localparam int CNT_W  = $clog2(2 * DEPTH + 1);
  localparam int DIM_W  = $clog2(MAX_DIM + 1);
  localparam int PROD_W = 2 * ELEM_WIDTH;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [REG_W-1:0] d);
    logic [7:0] d8;
    logic [DIM_W-1:0] r;
    d8 = 8'(d);
    if (d8 == 8'd0)                r = DIM_W'(1);
    else if (d8 > 8'(MAX_DIM))     r = DIM_W'(MAX_DIM);
    else                           r = DIM_W'(d8);
    return r;
  endfunction

  // configuration
  logic [1:0]       op_mode;
  logic [REG_W-1:0] a_rows, a_cols, b_rows, b_cols;

  // stores
  logic signed [ELEM_WIDTH-1:0] a_store [DEPTH];
  logic signed [ELEM_WIDTH-1:0] b_store [DEPTH];

  logic [CNT_W-1:0]  load_count;
  logic [ADDR_W-1:0] read_count;

  // sequencing
  logic [ADDR_W-1:0] rem, base, pa, pb;
  logic [DIM_W-1:0]  k;

  // mac pipe
  logic signed [ELEM_WIDTH-1:0] a_rd, b_rd;
  logic                         rd_v, term_v;
  logic signed [RES_W-1:0]      term, acc;
  logic signed [PROD_W-1:0]     prod;

  logic [DIM_W-1:0]  ar, ac, br, bc, rc;
  logic [NA_W-1:0]   na, nb, nres;
  logic [ADDR_W-1:0] r_eff;
  logic              is_mul, res_last, shape_ok;

  assign ar = clamp_dim(a_rows);
  assign ac = clamp_dim(a_cols);
  assign br = clamp_dim(b_rows);
  assign bc = clamp_dim(b_cols);
  assign na = NA_W'(ar) * NA_W'(ac);
  assign nb = NA_W'(br) * NA_W'(bc);
  assign is_mul = (op_mode == OP_MUL);
  assign rc = is_mul ? bc : ac;
  assign nres = NA_W'(ar) * NA_W'(rc);

  always_comb begin
    unique case (op_mode)
      OP_ADD, OP_SUB: shape_ok = (ar == br) && (ac == bc);
      OP_MUL:         shape_ok = (ac == br);
      default:        shape_ok = 1'b0;
    endcase
  end

  // read index past the end sticks at the final element
  assign r_eff = (NA_W'(read_count) >= nres) ? ADDR_W'(nres - NA_W'(1)) : read_count;
  assign res_last = (NA_W'(r_eff) + NA_W'(1)) >= nres;

  assign prod = a_rd * b_rd;

  assign stat.loaded_all = load_count >= (CNT_W'(na) + CNT_W'(nb));
  assign stat.shape_ok   = shape_ok;
  assign stat.div_done   = NA_W'(rem) < NA_W'(rc);
  assign stat.issue_last = !is_mul || ((k + DIM_W'(1)) == ac);
  assign stat.pipe_busy  = rd_v || term_v;
  assign stat.out_free   = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      op_mode <= OP_MUL;
      a_rows  <= REG_W'(16);
      a_cols  <= REG_W'(16);
      b_rows  <= REG_W'(16);
      b_cols  <= REG_W'(16);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_OP_MODE: op_mode <= cfg_data[1:0];
        REG_A_ROWS:  a_rows  <= cfg_data;
        REG_A_COLS:  a_cols  <= cfg_data;
        REG_B_ROWS:  b_rows  <= cfg_data;
        REG_B_COLS:  b_cols  <= cfg_data;
        default: ;
      endcase
    end
  end

  // store writes: a fills first, then b
  always_ff @(posedge clk) begin
    if (cmd.load_elem) begin
      if (load_count < CNT_W'(na)) begin
        a_store[ADDR_W'(load_count)] <= ELEM_WIDTH'(element);
      end else if (!stat.loaded_all) begin
        b_store[ADDR_W'(load_count - CNT_W'(na))] <= ELEM_WIDTH'(element);
      end
    end
  end

  // registered store reads
  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      a_rd <= a_store[pa];
      b_rd <= b_store[pb];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      load_count <= '0;
      read_count <= '0;
    end else if (cmd.load_elem && !stat.loaded_all) begin
      load_count <= load_count + CNT_W'(1);
    end else if (cmd.out_load) begin
      unique case (cmd.out_kind)
        OUT_OK: begin
          if (res_last) begin
            load_count <= '0;
            read_count <= '0;
          end else begin
            read_count <= r_eff + ADDR_W'(1);
          end
        end
        OUT_MISMATCH: begin
          load_count <= '0;
          read_count <= '0;
        end
        OUT_EARLY: ;
        default: ;
      endcase
    end
  end

  // row divide by repeated subtraction, with i*a_cols built alongside
  always_ff @(posedge clk) begin
    if (cmd.read_start) begin
      rem  <= r_eff;
      base <= '0;
    end else if (cmd.div_step) begin
      rem  <= rem - ADDR_W'(rc);
      base <= base + ADDR_W'(ac);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mac_init) begin
      pa <= is_mul ? base : base + rem;
      pb <= is_mul ? rem : base + rem;
      k  <= '0;
    end else if (cmd.issue) begin
      pa <= pa + ADDR_W'(1);
      pb <= pb + ADDR_W'(bc);
      k  <= k + DIM_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_v   <= 1'b0;
      term_v <= 1'b0;
    end else begin
      rd_v   <= cmd.issue;
      term_v <= rd_v;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_v) begin
      unique case (op_mode)
        OP_ADD:  term <= RES_W'(a_rd) + RES_W'(b_rd);
        OP_SUB:  term <= RES_W'(a_rd) - RES_W'(b_rd);
        default: term <= RES_W'(prod);
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mac_init) begin
      acc <= '0;
    end else if (term_v) begin
      acc <= acc + term;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      unique case (cmd.out_kind)
        OUT_OK: begin
          result_value <= acc;
          is_last      <= res_last;
          status       <= STAT_OK;
        end
        OUT_MISMATCH: begin
          result_value <= '0;
          is_last      <= 1'b1;
          status       <= STAT_MISMATCH;
        end
        OUT_EARLY: begin
          result_value <= '0;
          is_last      <= 1'b0;
          status       <= STAT_EARLY;
        end
        default: begin
          result_value <= '0;
          is_last      <= 1'b0;
          status       <= STAT_EARLY;
        end
      endcase
    end
  end

endmodule

// ----- rtl/matrix_add_sub_multiply_engine.sv -----
// ----------------------------------------------------------------------------
// matrix_add_sub_multiply_engine
// integer matrix engine: loads a then b, returns a+b, a-b or a*b per read
// ----------------------------------------------------------------------------
//
//   channel   direction   handshake               payload
//   in        to block    in_valid / in_stall     req_type, element
//   out       from block  out_valid / out_stall   result_value, is_last, status
//   cfg       to block    cfg_we                  cfg_index, cfg_data
//
// a load item is taken at once and the block stays open for the next
// a read of element (i, j) passes the row divider, then n issues to the
// single multiply-accumulate unit (n is a_cols for a product, 1 for add and
// subtract), then drains its pipe of read, term and accumulate registers and
// hands over; early reads and shape mismatches go straight to hand-over
// sync reset clears counts and pipe flags, sets a 16x16 mul; stores need none
// a result held by out_stall sits in the output register while a new item is
// taken; the next read waits only at its own hand-over
// ----------------------------------------------------------------------------
module matrix_add_sub_multiply_engine
  import masme_pkg::*;
#(
  parameter int MAX_DIM    = 16,
  parameter int ELEM_WIDTH = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  // configuration write port
  input  logic                     cfg_we,
  input  logic [IDX_W-1:0]         cfg_index,
  input  logic [REG_W-1:0]         cfg_data,
  // input items
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     req_type,
  input  logic signed [ELEM_W-1:0] element,
  // result items
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [RES_W-1:0]  result_value,
  output logic                     is_last,
  output logic [1:0]               status
);

  // command and status between the sequencer and the datapath
  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  // sequencer: decides outcome of a read and paces the mac
  masme_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .req_type (req_type),
    .stat     (stat),
    .in_stall (in_stall),
    .cmd      (cmd)
  );

  // datapath: stores, counters, divider, mac and output register
  masme_dp #(
    .MAX_DIM    (MAX_DIM),
    .ELEM_WIDTH (ELEM_WIDTH)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .element      (element),
    .cmd          (cmd),
    .out_stall    (out_stall),
    .stat         (stat),
    .out_valid    (out_valid),
    .result_value (result_value),
    .is_last      (is_last),
    .status       (status)
  );

endmodule

// ----- rtl/masme_checker.sv -----
// ----------------------------------------------------------------------------
// masme_checker
// port-level checks on the matrix engine, bound to the top level
// ----------------------------------------------------------------------------
module masme_checker
  import masme_pkg::*;
(
  input logic                     clk,
  input logic                     rst,
  input logic                     in_valid,
  input logic                     in_stall,
  input logic                     req_type,
  input logic                     out_valid,
  input logic                     out_stall,
  input logic signed [RES_W-1:0]  result_value,
  input logic                     is_last,
  input logic [1:0]               status
);

  // a held result keeps its value
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(result_value) && $stable(status))
    else $error("held result changed");

  // any status other than ok carries a zero value
  a_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != STAT_OK |-> result_value == '0)
    else $error("non-zero value with error status");

  // a mismatch ends the pair, an early read never does
  a_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == STAT_MISMATCH || status == STAT_EARLY)
      |-> is_last == (status == STAT_MISMATCH))
    else $error("is_last wrong for error status");

  // a read item closes the input until its result is handed over
  a_read_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && req_type |=> in_stall)
    else $error("input open while a read is in flight");

  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind matrix_add_sub_multiply_engine masme_checker u_masme_checker (.*);
